// ===== rtl/lpcs_pkg.sv =====
package lpcs_pkg;

  localparam int GRID_SIDE       = 32;
  localparam int COORD_FRAC_BITS = 8;
  localparam int T_FRAC_BITS     = 16;

  localparam int COORD_W = 13;
  localparam int CELL_W  = COORD_W - COORD_FRAC_BITS;
  localparam int AD_W    = COORD_W;
  localparam int NUM_W   = AD_W + 1;
  localparam int T_W     = T_FRAC_BITS + 1;
  localparam int PROD_W  = T_W + AD_W;
  localparam int RND_W   = PROD_W + 1 - T_FRAC_BITS;
  localparam int SUM_W   = COORD_W + 3;
  localparam int STEP_W  = $clog2(T_W + 1);

  localparam int MAX_CROSS = 63;
  localparam int CNT_W     = 6;

  localparam int LIM_INT = (GRID_SIDE * (2 ** COORD_FRAC_BITS) - 1) > 8191 ?
                           8191 : (GRID_SIDE * (2 ** COORD_FRAC_BITS) - 1);
  localparam logic [COORD_W-1:0] COORD_LIM = COORD_W'(LIM_INT);
  localparam logic [NUM_W-1:0]   CELL_ONE  = NUM_W'(2 ** COORD_FRAC_BITS);
  localparam logic [RND_W+T_FRAC_BITS-1:0] T_HALF =
    (RND_W + T_FRAC_BITS)'(2 ** (T_FRAC_BITS - 1));

  typedef struct packed {
    logic             active;
    logic             neg;
    logic [AD_W-1:0]  ad;
    logic [NUM_W-1:0] num;
  } axis_t;

  typedef struct packed {
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    axis_t              ax;
    axis_t              ay;
  } line_t;

  typedef struct packed {
    logic           start;
    logic [AD_W-1:0] num;
    logic [AD_W-1:0] den;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PICK,
    ST_DIV,
    ST_MUL,
    ST_EMIT,
    ST_FINAL
  } walk_state_e;

endpackage

// ===== rtl/lpcs_if.sv =====
interface lpcs_line_if;
  logic                           valid;
  logic                           ready;
  logic [lpcs_pkg::COORD_W-1:0]   begin_x;
  logic [lpcs_pkg::COORD_W-1:0]   begin_y;
  logic [lpcs_pkg::COORD_W-1:0]   end_x;
  logic [lpcs_pkg::COORD_W-1:0]   end_y;

  modport source (output valid, begin_x, begin_y, end_x, end_y, input ready);
  modport sink (input valid, begin_x, begin_y, end_x, end_y, output ready);
endinterface

interface lpcs_piece_if;
  logic                           valid;
  logic                           ready;
  logic [lpcs_pkg::COORD_W-1:0]   piece_begin_x;
  logic [lpcs_pkg::COORD_W-1:0]   piece_begin_y;
  logic [lpcs_pkg::COORD_W-1:0]   piece_end_x;
  logic [lpcs_pkg::COORD_W-1:0]   piece_end_y;
  logic [lpcs_pkg::CELL_W-1:0]    cell_x;
  logic [lpcs_pkg::CELL_W-1:0]    cell_y;
  logic                           last_piece;

  modport source (output valid, piece_begin_x, piece_begin_y, piece_end_x, piece_end_y,
                  cell_x, cell_y, last_piece, input ready);
  modport sink (input valid, piece_begin_x, piece_begin_y, piece_end_x, piece_end_y,
                cell_x, cell_y, last_piece, output ready);
endinterface

// ===== rtl/lpcs_front.sv =====
module lpcs_front (
  lpcs_line_if.sink       line_i,
  input  logic            full_i,
  output logic            push_o,
  output lpcs_pkg::line_t line_o
);

  function automatic logic [lpcs_pkg::COORD_W-1:0] sat(
    input logic [lpcs_pkg::COORD_W-1:0] v
  );
    return (v > lpcs_pkg::COORD_LIM) ? lpcs_pkg::COORD_LIM : v;
  endfunction

  function automatic lpcs_pkg::axis_t setup(
    input logic [lpcs_pkg::COORD_W-1:0] b,
    input logic [lpcs_pkg::COORD_W-1:0] e
  );
    lpcs_pkg::axis_t                          a;
    logic [lpcs_pkg::COORD_FRAC_BITS-1:0]     frac;
    frac     = b[lpcs_pkg::COORD_FRAC_BITS-1:0];
    a.active = (e != b);
    a.neg    = (e < b);
    a.ad     = a.neg ? (b - e) : (e - b);
    // Moving upwards the first edge is one cell minus the fraction away,
    // or zero when the start lies on an edge.
    if (a.active && !a.neg) begin
      a.num = lpcs_pkg::NUM_W'(lpcs_pkg::COORD_FRAC_BITS'(0 - frac));
    end else begin
      a.num = lpcs_pkg::NUM_W'(frac);
    end
    return a;
  endfunction

  logic [lpcs_pkg::COORD_W-1:0] bx, by, ex, ey;

  assign bx = sat(line_i.begin_x);
  assign by = sat(line_i.begin_y);
  assign ex = sat(line_i.end_x);
  assign ey = sat(line_i.end_y);

  assign line_i.ready = !full_i;
  assign push_o       = line_i.valid && !full_i;

  always_comb begin
    line_o.bx = bx;
    line_o.by = by;
    line_o.ex = ex;
    line_o.ey = ey;
    line_o.ax = setup(bx, ex);
    line_o.ay = setup(by, ey);
  end

endmodule

// ===== rtl/lpcs_queue.sv =====
module lpcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpcs_pkg::line_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output lpcs_pkg::line_t data_o
);

  lpcs_pkg::line_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign avail_o = (fill_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lpcs_div.sv =====
module lpcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpcs_pkg::div_req_t         req_i,
  output logic                       done_o,
  output logic [lpcs_pkg::T_W-1:0]   quot_o
);

  // Numerator never exceeds the divisor, so the walk starts with the
  // remainder equal to the numerator and yields one quotient bit a cycle.
  logic [lpcs_pkg::NUM_W-1:0]  rem_q;
  logic [lpcs_pkg::AD_W-1:0]   den_q;
  logic [lpcs_pkg::T_W-1:0]    quot_q;
  logic [lpcs_pkg::STEP_W-1:0] step_q;
  logic                        done_q;
  logic                        ge;
  logic [lpcs_pkg::NUM_W-1:0]  rs;

  assign ge     = (rem_q >= {1'b0, den_q});
  assign rs     = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        step_q <= lpcs_pkg::STEP_W'(lpcs_pkg::T_W);
      end else if (step_q != '0) begin
        step_q <= step_q - 1'b1;
        if (step_q == lpcs_pkg::STEP_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= lpcs_pkg::NUM_W'(req_i.num);
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (step_q != '0) begin
      rem_q  <= {rs[lpcs_pkg::NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[lpcs_pkg::T_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/lpcs_back.sv =====
module lpcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  lpcs_pkg::line_t   line_i,
  output logic              pop_o,
  lpcs_piece_if.source      piece_o
);

  function automatic logic [lpcs_pkg::COORD_W-1:0] point(
    input logic [lpcs_pkg::COORD_W-1:0] b,
    input logic                         neg,
    input logic [lpcs_pkg::PROD_W-1:0]  prod
  );
    logic [lpcs_pkg::RND_W+lpcs_pkg::T_FRAC_BITS-1:0] rsum;
    logic [lpcs_pkg::SUM_W-1:0]                       r;
    logic [lpcs_pkg::SUM_W-1:0]                       s;
    logic [lpcs_pkg::COORD_W-1:0]                     v;
    rsum = (lpcs_pkg::RND_W + lpcs_pkg::T_FRAC_BITS)'(prod) + lpcs_pkg::T_HALF;
    r    = lpcs_pkg::SUM_W'(rsum[lpcs_pkg::RND_W+lpcs_pkg::T_FRAC_BITS-1:
                                 lpcs_pkg::T_FRAC_BITS]);
    if (neg) begin
      v = (r > lpcs_pkg::SUM_W'(b)) ? '0 : lpcs_pkg::COORD_W'(lpcs_pkg::SUM_W'(b) - r);
    end else begin
      s = lpcs_pkg::SUM_W'(b) + r;
      v = (s > lpcs_pkg::SUM_W'(lpcs_pkg::COORD_LIM)) ? lpcs_pkg::COORD_LIM :
          lpcs_pkg::COORD_W'(s);
    end
    return v;
  endfunction

  lpcs_pkg::walk_state_e         state_q, state_d;
  lpcs_pkg::line_t               line_q;
  logic [lpcs_pkg::COORD_W-1:0]  px_q, py_q;
  logic [lpcs_pkg::T_W-1:0]      prev_t_q, t_q, tx_q, ty_q;
  logic [lpcs_pkg::CNT_W-1:0]    cnt_q;
  logic                          needx_q, needy_q, sel_y_q;
  logic [lpcs_pkg::PROD_W-1:0]   prodx_q, prody_q;

  logic                          out_valid_q;
  logic [lpcs_pkg::COORD_W-1:0]  o_bx_q, o_by_q, o_ex_q, o_ey_q;
  logic [lpcs_pkg::CELL_W-1:0]   o_cx_q, o_cy_q;
  logic                          o_last_q;

  lpcs_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [lpcs_pkg::T_W-1:0]      quot;

  logic                          vx, vy, take_x, slot_free;
  logic [lpcs_pkg::T_W-1:0]      t_pick;
  logic [lpcs_pkg::COORD_W-1:0]  nx, ny;
  logic [lpcs_pkg::COORD_W-1:0]  emit_mx, emit_my, fin_mx, fin_my;

  lpcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign vx = line_q.ax.active && (line_q.ax.num <= {1'b0, line_q.ax.ad});
  assign vy = line_q.ay.active && (line_q.ay.num <= {1'b0, line_q.ay.ad});
  // On equal t the crossing on the y axis wins.
  assign take_x    = vx && (!vy || (tx_q < ty_q));
  assign t_pick    = take_x ? tx_q : ty_q;
  assign slot_free = !out_valid_q || piece_o.ready;
  assign nx        = point(line_q.bx, line_q.ax.neg, prodx_q);
  assign ny        = point(line_q.by, line_q.ay.neg, prody_q);
  assign emit_mx   = (px_q < nx) ? px_q : nx;
  assign emit_my   = (py_q < ny) ? py_q : ny;
  assign fin_mx    = (px_q < line_q.ex) ? px_q : line_q.ex;
  assign fin_my    = (py_q < line_q.ey) ? py_q : line_q.ey;

  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = line_q.ay.num[lpcs_pkg::AD_W-1:0];
    div_req.den   = line_q.ay.ad;
    if (needx_q && vx) begin
      div_req.num = line_q.ax.num[lpcs_pkg::AD_W-1:0];
      div_req.den = line_q.ax.ad;
    end
    case (state_q)
      lpcs_pkg::ST_LOAD: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          state_d = lpcs_pkg::ST_PICK;
        end
      end
      lpcs_pkg::ST_PICK: begin
        if ((needx_q && vx) || (needy_q && vy)) begin
          div_req.start = 1'b1;
          state_d       = lpcs_pkg::ST_DIV;
        end else if ((cnt_q == lpcs_pkg::CNT_W'(lpcs_pkg::MAX_CROSS)) || (!vx && !vy)) begin
          state_d = lpcs_pkg::ST_FINAL;
        end else if (t_pick != prev_t_q) begin
          state_d = lpcs_pkg::ST_MUL;
        end
      end
      lpcs_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lpcs_pkg::ST_PICK;
        end
      end
      lpcs_pkg::ST_MUL: begin
        state_d = lpcs_pkg::ST_EMIT;
      end
      lpcs_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = lpcs_pkg::ST_PICK;
        end
      end
      lpcs_pkg::ST_FINAL: begin
        if (slot_free) begin
          state_d = lpcs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = lpcs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpcs_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (piece_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == lpcs_pkg::ST_EMIT || state_q == lpcs_pkg::ST_FINAL) && slot_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lpcs_pkg::ST_LOAD: begin
        line_q   <= line_i;
        px_q     <= line_i.bx;
        py_q     <= line_i.by;
        prev_t_q <= '0;
        cnt_q    <= '0;
        needx_q  <= 1'b1;
        needy_q  <= 1'b1;
      end
      lpcs_pkg::ST_PICK: begin
        if ((needx_q && vx) || (needy_q && vy)) begin
          sel_y_q <= !(needx_q && vx);
        end else if (!((cnt_q == lpcs_pkg::CNT_W'(lpcs_pkg::MAX_CROSS)) || (!vx && !vy))) begin
          t_q <= t_pick;
          if (take_x) begin
            line_q.ax.num <= line_q.ax.num + lpcs_pkg::CELL_ONE;
            needx_q       <= 1'b1;
          end else begin
            line_q.ay.num <= line_q.ay.num + lpcs_pkg::CELL_ONE;
            needy_q       <= 1'b1;
          end
        end
      end
      lpcs_pkg::ST_DIV: begin
        if (div_done) begin
          if (sel_y_q) begin
            ty_q    <= quot;
            needy_q <= 1'b0;
          end else begin
            tx_q    <= quot;
            needx_q <= 1'b0;
          end
        end
      end
      lpcs_pkg::ST_MUL: begin
        prodx_q <= lpcs_pkg::PROD_W'(t_q) * lpcs_pkg::PROD_W'(line_q.ax.ad);
        prody_q <= lpcs_pkg::PROD_W'(t_q) * lpcs_pkg::PROD_W'(line_q.ay.ad);
      end
      lpcs_pkg::ST_EMIT: begin
        if (slot_free) begin
          o_bx_q   <= px_q;
          o_by_q   <= py_q;
          o_ex_q   <= nx;
          o_ey_q   <= ny;
          o_cx_q   <= emit_mx[lpcs_pkg::COORD_W-1:lpcs_pkg::COORD_FRAC_BITS];
          o_cy_q   <= emit_my[lpcs_pkg::COORD_W-1:lpcs_pkg::COORD_FRAC_BITS];
          o_last_q <= 1'b0;
          px_q     <= nx;
          py_q     <= ny;
          prev_t_q <= t_q;
          cnt_q    <= cnt_q + 1'b1;
        end
      end
      lpcs_pkg::ST_FINAL: begin
        if (slot_free) begin
          o_bx_q   <= px_q;
          o_by_q   <= py_q;
          o_ex_q   <= line_q.ex;
          o_ey_q   <= line_q.ey;
          o_cx_q   <= fin_mx[lpcs_pkg::COORD_W-1:lpcs_pkg::COORD_FRAC_BITS];
          o_cy_q   <= fin_my[lpcs_pkg::COORD_W-1:lpcs_pkg::COORD_FRAC_BITS];
          o_last_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign piece_o.valid         = out_valid_q;
  assign piece_o.piece_begin_x = o_bx_q;
  assign piece_o.piece_begin_y = o_by_q;
  assign piece_o.piece_end_x   = o_ex_q;
  assign piece_o.piece_end_y   = o_ey_q;
  assign piece_o.cell_x        = o_cx_q;
  assign piece_o.cell_y        = o_cy_q;
  assign piece_o.last_piece    = o_last_q;

endmodule

// ===== rtl/line_pixel_crossing_splitter.sv =====
// Splits one line segment on a pixel grid into pieces, one per pixel-edge
// crossing, each tagged with its pixel cell, plus a final piece to the end.
// Channels: line_i takes one transaction per line (begin and end points,
// Q5.8); piece_o gives one transaction per piece, the last one flagged by
// last_piece. Both use valid/ready, a transaction moving when both are high.
// A front stage saturates and prepares each line and writes it into a
// two-entry queue, so up to two further lines are taken while one is walked.
// For each crossing that yields a piece the walker starts the one-bit-a-cycle
// divider that finds the crossing's t, waits until its quotient is back, then
// picks, multiplies and emits. Skipped crossings take the division and the
// pick alone, and a line that moves on both axes also divides at its start
// to find the first t of the second axis. The output register lets the
// walker continue while a piece waits; when the receiver stalls, the walker
// stops at its next piece and the queue then fills and drops ready on
// line_i. Reset empties the queue, drops piece_o.valid and returns the
// walker to waiting for a line.
module line_pixel_crossing_splitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpcs_line_if.sink     line_i,
  lpcs_piece_if.source  piece_o
);

  lpcs_pkg::line_t front_line, queue_line;
  logic            push, full, pop, avail;

  lpcs_front u_front (
    .line_i (line_i),
    .full_i (full),
    .push_o (push),
    .line_o (front_line)
  );

  lpcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_line),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (queue_line)
  );

  lpcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .line_i  (queue_line),
    .pop_o   (pop),
    .piece_o (piece_o)
  );

endmodule
